FILE: hw/rtl/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg - shared definitions for the deque with search
// Depth, field widths, action and status codes, cell control and result types.
// ----------------------------------------------------------------------------
package dws_pkg;

   localparam int DEPTH   = 16;
   localparam int INDEX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef logic signed [31:0] word_type;
   typedef logic [2:0]         action_type;
   typedef logic [1:0]         status_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam action_type ACT_PUSH_FRONT = 3'd0;
   localparam action_type ACT_POP_FRONT  = 3'd1;
   localparam action_type ACT_PUSH_BACK  = 3'd2;
   localparam action_type ACT_POP_BACK   = 3'd3;
   localparam action_type ACT_FIND       = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_BACK = 2'd1,  // take the word of the neighbor toward the front
      CELL_SHIFT_FWD  = 2'd2,  // take the word of the neighbor toward the back
      CELL_LOAD_TAIL  = 2'd3   // the cell at the tail takes the value
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      word_type    value;
   } cell_ctrl_type;

   typedef struct packed {
      status_type  status;
      word_type    popped_value;
      logic        found;
      logic [3:0]  match_position;
      logic [4:0]  occupancy;
   } rsp_item_type;

endpackage

FILE: hw/rtl/dws_if.sv
// ----------------------------------------------------------------------------
// dws_req_if / dws_rsp_if - request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dws_req_if;
   import dws_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   word_type   value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface dws_rsp_if;
   import dws_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   word_type   popped_value;
   logic       found;
   logic [3:0] match_position;
   logic [4:0] occupancy;

   modport source (output valid, output status, output popped_value, output found,
                   output match_position, output occupancy, input ready);
   modport sink   (input valid, input status, input popped_value, input found,
                   input match_position, input occupancy, output ready);
endinterface

FILE: hw/rtl/dws_cell.sv
// ----------------------------------------------------------------------------
// dws_cell - one storage cell of the deque
// Holds one word, shifts toward either neighbor, loads at the tail, compares.
// ----------------------------------------------------------------------------
module dws_cell (
   input  logic                   clock,
   input  dws_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   at_tail,
   input  dws_pkg::word_type      front_word,
   input  dws_pkg::word_type      back_word,
   output dws_pkg::word_type      word,
   output logic                   match
);
   import dws_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         CELL_HOLD:       word_in = word_ff;
         CELL_SHIFT_BACK: word_in = front_word;
         CELL_SHIFT_FWD:  word_in = back_word;
         CELL_LOAD_TAIL:  word_in = at_tail ? ctrl.value : word_ff;
         default:         word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = occupied && (word_ff == ctrl.value);

endmodule

FILE: hw/rtl/dws_first_match.sv
// ----------------------------------------------------------------------------
// dws_first_match - priority encoder over the cell match lines
// Reports whether any cell matched and the index of the one nearest the front.
// ----------------------------------------------------------------------------
module dws_first_match (
   input  logic [dws_pkg::DEPTH-1:0] hits,
   output logic                      found,
   output dws_pkg::index_type        position
);
   import dws_pkg::*;

   always_comb begin
      position = '0;
      // scan from the back so the frontmost hit wins
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hits[i]) begin
            position = INDEX_W'(i);
         end
      end
   end

   assign found = |hits;

endmodule

FILE: hw/rtl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search - bounded double-ended queue with find
// Row of word cells shifted and compared in parallel; result via output buffer.
// ----------------------------------------------------------------------------
// The result beat is registered; while the response channel stalls it waits in the output buffer.
// Throughput: one request per cycle while the skid entry is empty; every cell shifts or compares in that cycle.
// A two-entry output buffer keeps taking one more request while a result waits.
// Reset clears the entry count and the output buffer; cell words stay undefined
// until written and are never read before that.
module deque_with_search (
   input  logic      clock,
   input  logic      reset,
   dws_req_if.sink   req_chan,
   dws_rsp_if.source rsp_chan
);
   import dws_pkg::*;

   count_type     count_ff;
   count_type     count_in;
   cell_ctrl_type ctrl;
   word_type      words [DEPTH];
   logic [DEPTH-1:0] hits;
   logic          any_hit;
   index_type     hit_pos;
   rsp_item_type  result;

   rsp_item_type  out_ff, out_in, skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept;
   logic deliver;
   logic is_full;
   logic is_empty;
   count_type last_idx;
   logic [INDEX_W+3:0] pos_wide;
   logic [COUNT_W+4:0] count_wide;

   assign req_chan.ready = !skid_valid_ff;
   assign accept  = req_chan.valid && req_chan.ready;
   assign deliver = out_valid_ff && rsp_chan.ready;

   assign is_full  = (count_ff == COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign last_idx = count_ff - COUNT_W'(1);

   // ---- cell row ----
   always_comb begin
      ctrl.value = req_chan.value;
      ctrl.op    = CELL_HOLD;
      if (accept) begin
         case (req_chan.action)
            ACT_PUSH_FRONT: ctrl.op = is_full  ? CELL_HOLD : CELL_SHIFT_BACK;
            ACT_POP_FRONT:  ctrl.op = is_empty ? CELL_HOLD : CELL_SHIFT_FWD;
            ACT_PUSH_BACK:  ctrl.op = is_full  ? CELL_HOLD : CELL_LOAD_TAIL;
            default:        ctrl.op = CELL_HOLD;
         endcase
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      dws_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (COUNT_W'(g) < count_ff),
         .at_tail    (COUNT_W'(g) == count_ff),
         .front_word ((g == 0) ? req_chan.value : words[(g == 0) ? 0 : g - 1]),
         .back_word  (words[(g == DEPTH - 1) ? g : g + 1]),
         .word       (words[g]),
         .match      (hits[g])
      );
   end

   dws_first_match u_first_match (
      .hits     (hits),
      .found    (any_hit),
      .position (hit_pos)
   );

   // ---- result and count ----
   always_comb begin
      count_in              = count_ff;
      result.status         = ST_OK;
      result.popped_value   = '0;
      result.found          = 1'b0;
      pos_wide              = '0;
      case (req_chan.action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (is_full) begin
               result.status = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (is_empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.popped_value = words[0];
               count_in            = last_idx;
            end
         end
         ACT_POP_BACK: begin
            if (is_empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.popped_value = words[last_idx[INDEX_W-1:0]];
               count_in            = last_idx;
            end
         end
         ACT_FIND: begin
            result.found = any_hit;
            pos_wide     = {4'b0, hit_pos};
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      count_wide            = {5'b0, count_in};
      result.match_position = pos_wide[3:0];
      result.occupancy      = count_wide[4:0];
   end

   // ---- output buffer: head register plus one skid entry ----
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (deliver) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.popped_value   = out_ff.popped_value;
   assign rsp_chan.found          = out_ff.found;
   assign rsp_chan.match_position = out_ff.match_position;
   assign rsp_chan.occupancy      = out_ff.occupancy;

endmodule
